>>> hw/rtl/bpm_pkg.sv
// Package for the bracket pair matcher: character codes, bracket kinds,
// the per-cell command struct and parameter defaults. No dependencies.
package bpm_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int ROW_BITS_DEF    = 16;
   localparam int COL_BITS_DEF    = 12;

   localparam logic [7:0] CH_LROUND  = 8'h28;
   localparam logic [7:0] CH_RROUND  = 8'h29;
   localparam logic [7:0] CH_LCURLY  = 8'h7b;
   localparam logic [7:0] CH_RCURLY  = 8'h7d;
   localparam logic [7:0] CH_LSQUARE = 8'h5b;
   localparam logic [7:0] CH_RSQUARE = 8'h5d;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_AT      = 8'h40;

   localparam logic [1:0] KIND_ROUND  = 2'd0;
   localparam logic [1:0] KIND_CURLY  = 2'd1;
   localparam logic [1:0] KIND_SQUARE = 2'd2;
   localparam logic [1:0] KIND_DOUBLE = 2'd3;

   localparam logic [1:0] LEN_SINGLE = 2'd1;
   localparam logic [1:0] LEN_DOUBLE = 2'd2;

   typedef struct packed {
      logic push;
      logic pop;
      logic set_nb;
   } cell_op_type;

endpackage

>>> hw/rtl/bpm_cell.sv
// One stack cell of the bracket pair matcher: holds a single frame and
// shifts it to or from its neighbours. Depends on bpm_pkg.
module bpm_cell #(
   parameter int FRAME_W = bpm_pkg::ROW_BITS_DEF + bpm_pkg::COL_BITS_DEF + 3
) (
   input  logic                 clock,
   input  bpm_pkg::cell_op_type op,
   input  logic [FRAME_W-1:0]   above,
   input  logic [FRAME_W-1:0]   below,
   output logic [FRAME_W-1:0]   frame
);
   import bpm_pkg::*;

   logic [FRAME_W-1:0] frame_ff;
   logic [FRAME_W-1:0] frame_in;

   // bit 0 is the non-blank mark
   always_comb begin
      frame_in = frame_ff;
      if (op.push) begin
         frame_in = above;
      end else if (op.pop) begin
         frame_in = below;
      end
      frame_in[0] = frame_in[0] | op.set_nb;
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign frame = frame_ff;

endmodule

>>> hw/rtl/bracket_pair_matcher.sv
// Bracket pair matcher: stack of open brackets as a chain of shifting cells.
// The result is registered; the top cell and count decide each step.
// Throughput: one character per cycle unless an untaken result stalls input.
// Reset clears stack count, skip, overflow and rsp valid; cells are not reset.
// Depends on bpm_pkg and bpm_cell.
module bracket_pair_matcher #(
   parameter int STACK_DEPTH = bpm_pkg::STACK_DEPTH_DEF,
   parameter int ROW_BITS    = bpm_pkg::ROW_BITS_DEF,
   parameter int COL_BITS    = bpm_pkg::COL_BITS_DEF,
   localparam int REQ_W = ((ROW_BITS + COL_BITS + 17 + 7) / 8) * 8,
   localparam int RSP_W = ((2 * ROW_BITS + 2 * COL_BITS + 5 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // row, col, ch, next_ch, has_next, zero pad
   input  logic [0:0]       req_tuser,  // start_of_text
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // open_row, open_col, open_len, close_row,
                                        // close_col, close_len, overflowed, zero pad
   output logic [1:0]       rsp_tuser   // pair_kind
);
   import bpm_pkg::*;

   localparam int FRAME_W = ROW_BITS + COL_BITS + 3;
   localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
   localparam int PAY_W   = 2 * ROW_BITS + 2 * COL_BITS + 5;

   logic                accept;
   logic                sot;
   logic [ROW_BITS-1:0] row;
   logic [COL_BITS-1:0] col;
   logic [7:0]          ch;
   logic [7:0]          nx;
   logic                hn;

   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt0;
   logic             skip_ff, skip_in, skip0;
   logic             ovf_ff, ovf_in, ovf0;

   logic [FRAME_W-1:0]  frames [STACK_DEPTH];
   logic [FRAME_W-1:0]  new_frame;
   logic [ROW_BITS-1:0] top_row;
   logic [COL_BITS-1:0] top_col;
   logic [1:0]          top_kind;
   logic                top_nb;
   logic                not_empty;

   logic       do_push, do_pop, do_mark, emit;
   logic [1:0] push_kind, want_kind, close_len;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PAY_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]       rsp_kind_ff, rsp_kind_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign row = req_tdata[ROW_BITS-1:0];
   assign col = req_tdata[ROW_BITS +: COL_BITS];
   assign ch  = req_tdata[ROW_BITS + COL_BITS +: 8];
   assign nx  = req_tdata[ROW_BITS + COL_BITS + 8 +: 8];
   assign hn  = req_tdata[ROW_BITS + COL_BITS + 16];
   assign sot = req_tuser[0];

   assign top_row  = frames[0][FRAME_W-1 -: ROW_BITS];
   assign top_col  = frames[0][COL_BITS+2:3];
   assign top_kind = frames[0][2:1];
   assign top_nb   = frames[0][0];

   assign cnt0      = sot ? '0 : cnt_ff;
   assign skip0     = sot ? 1'b0 : skip_ff;
   assign ovf0      = sot ? 1'b0 : ovf_ff;
   assign not_empty = (cnt0 != '0);

   always_comb begin
      do_push   = 1'b0;
      do_pop    = 1'b0;
      do_mark   = 1'b0;
      push_kind = KIND_ROUND;
      want_kind = KIND_ROUND;
      close_len = LEN_SINGLE;
      skip_in   = 1'b0;
      if (!skip0) begin
         if (ch == CH_LSQUARE && hn && nx == CH_LSQUARE) begin
            do_push   = 1'b1;
            push_kind = KIND_DOUBLE;
            skip_in   = 1'b1;
         end else if (ch == CH_RSQUARE && hn && nx == CH_RSQUARE && not_empty
                      && top_kind == KIND_DOUBLE) begin
            do_pop    = 1'b1;
            close_len = LEN_DOUBLE;
            skip_in   = 1'b1;
         end else if (ch == CH_LROUND) begin
            do_push   = 1'b1;
            push_kind = KIND_ROUND;
         end else if (ch == CH_LCURLY) begin
            do_push   = 1'b1;
            push_kind = KIND_CURLY;
         end else if (ch == CH_LSQUARE) begin
            do_push   = 1'b1;
            push_kind = KIND_SQUARE;
         end else if (ch == CH_RROUND || ch == CH_RCURLY || ch == CH_RSQUARE) begin
            if (ch == CH_RROUND) begin
               want_kind = KIND_ROUND;
            end else if (ch == CH_RCURLY) begin
               want_kind = KIND_CURLY;
            end else begin
               want_kind = KIND_SQUARE;
            end
            if (not_empty && top_kind == want_kind) begin
               do_pop = 1'b1;
            end else begin
               do_mark = 1'b1;
            end
         end else if (ch != CH_SPACE && ch != CH_TAB && ch != CH_AT) begin
            do_mark = 1'b1;
         end
      end
      // full stack: push dropped, top still marked
      ovf_in = ovf0;
      if (do_push && cnt0 == CNT_W'(STACK_DEPTH)) begin
         do_push = 1'b0;
         do_mark = 1'b1;
         ovf_in  = 1'b1;
      end
      cnt_in = cnt0;
      if (do_push) begin
         cnt_in = cnt0 + CNT_W'(1);
      end else if (do_pop) begin
         cnt_in = cnt0 - CNT_W'(1);
      end
      emit = do_pop && (top_row != row || top_nb);
   end

   assign new_frame = {row, col, push_kind, 1'b0};

   genvar gi;
   generate
      for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
         cell_op_type        op;
         logic [FRAME_W-1:0] above;
         logic [FRAME_W-1:0] below;

         assign op.push = accept && do_push;
         assign op.pop  = accept && do_pop;
         if (gi == 0) begin : g_top
            assign op.set_nb = accept && (do_mark || do_pop);
            assign above     = new_frame;
         end else if (gi == 1) begin : g_second
            assign op.set_nb = accept && do_push;
            assign above     = frames[gi-1];
         end else begin : g_rest
            assign op.set_nb = 1'b0;
            assign above     = frames[gi-1];
         end
         if (gi == STACK_DEPTH - 1) begin : g_last
            assign below = frames[gi];
         end else begin : g_mid
            assign below = frames[gi+1];
         end

         bpm_cell #(
            .FRAME_W(FRAME_W)
         ) u_cell (
            .clock(clock),
            .op   (op),
            .above(above),
            .below(below),
            .frame(frames[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         skip_ff <= 1'b0;
         ovf_ff  <= 1'b0;
      end else if (accept) begin
         cnt_ff  <= cnt_in;
         skip_ff <= skip_in;
         ovf_ff  <= ovf_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (accept) begin
         rsp_valid_in = emit;
         rsp_data_in  = {ovf_in, close_len, col, row,
                         (top_kind == KIND_DOUBLE) ? LEN_DOUBLE : LEN_SINGLE,
                         top_col, top_row};
         rsp_kind_in  = top_kind;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - PAY_W){1'b0}}, rsp_data_ff};
   assign rsp_tuser  = rsp_kind_ff;

endmodule

>>> bench/tb_top.sv
// Self-checking bench for bracket_pair_matcher: directed table, then random text documents.
// Expected pairs come from a behavioural stack model kept here or from typed table rows, compared field by field.
// Depends on bpm_pkg and the bracket_pair_matcher RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bpm_pkg::*;

   localparam int DEPTH        = STACK_DEPTH_DEF;
   localparam int RANDOM_ITEMS = 1850;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam int SCRIPT_LEN   = 25;
   localparam logic [7:0] CH_UPPER_A = 8'h41;

   typedef struct packed {
      logic        sot;
      logic [15:0] row;
      logic [11:0] col;
      logic [7:0]  ch;
      logic [7:0]  nx;
      logic        hn;
   } char_t;

   typedef struct packed {
      logic [15:0] open_row;
      logic [11:0] open_col;
      logic [1:0]  open_len;
      logic [15:0] close_row;
      logic [11:0] close_col;
      logic [1:0]  close_len;
      logic [1:0]  kind;
      logic        ovf;
   } pair_t;

   typedef struct {
      char_t c;
      bit    typed;
      bit    hit;
      pair_t p;
   } script_row_t;

   localparam pair_t NO_PAIR = '0;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   bracket_pair_matcher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // model state
   logic [15:0] frame_row [DEPTH];
   logic [11:0] frame_col [DEPTH];
   logic [1:0]  frame_kind [DEPTH];
   bit          frame_nb [DEPTH];
   int          frame_count   = 0;
   bit          skip_pending  = 1'b0;
   bit          overflow_seen = 1'b0;

   pair_t       pending_pairs [$];
   int          mismatch_count = 0;
   bit          req_fast = 1'b0;
   bit          rsp_fast = 1'b0;

   // document generator state
   char_t       doc_chars [$];
   logic [7:0]  line_buf [$];
   int          open_kinds [$];
   logic [15:0] doc_row;
   bit          doc_first;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void mark_top();
      if (frame_count > 0) frame_nb[frame_count - 1] = 1'b1;
   endfunction

   function automatic void push_open(input char_t c, input logic [1:0] kind);
      mark_top();
      if (frame_count < DEPTH) begin
         frame_row[frame_count]  = c.row;
         frame_col[frame_count]  = c.col;
         frame_kind[frame_count] = kind;
         frame_nb[frame_count]   = 1'b0;
         frame_count++;
      end else begin
         overflow_seen = 1'b1;
      end
   endfunction

   function automatic bit top_is(input logic [1:0] kind);
      return frame_count > 0 && frame_kind[frame_count - 1] == kind;
   endfunction

   function automatic bit pop_pair(input char_t c, input logic [1:0] len, output pair_t p);
      int top;
      bit shown;
      top = frame_count - 1;
      frame_count--;
      shown = frame_row[top] != c.row || frame_nb[top];
      p.open_row  = frame_row[top];
      p.open_col  = frame_col[top];
      p.open_len  = (frame_kind[top] == KIND_DOUBLE) ? LEN_DOUBLE : LEN_SINGLE;
      p.close_row = c.row;
      p.close_col = c.col;
      p.close_len = len;
      p.kind      = frame_kind[top];
      p.ovf       = overflow_seen;
      mark_top();
      return shown;
   endfunction

   function automatic bit predict_pair(input char_t c, output pair_t p);
      logic [1:0] want;
      p = NO_PAIR;
      if (c.sot) begin
         frame_count   = 0;
         skip_pending  = 1'b0;
         overflow_seen = 1'b0;
      end
      if (skip_pending) begin
         skip_pending = 1'b0;
         return 1'b0;
      end
      if (c.ch == CH_LSQUARE && c.hn && c.nx == CH_LSQUARE) begin
         push_open(c, KIND_DOUBLE);
         skip_pending = 1'b1;
         return 1'b0;
      end
      if (c.ch == CH_RSQUARE && c.hn && c.nx == CH_RSQUARE && top_is(KIND_DOUBLE)) begin
         skip_pending = 1'b1;
         return pop_pair(c, LEN_DOUBLE, p);
      end
      case (c.ch)
         CH_LROUND: begin
            push_open(c, KIND_ROUND);
            return 1'b0;
         end
         CH_LCURLY: begin
            push_open(c, KIND_CURLY);
            return 1'b0;
         end
         CH_LSQUARE: begin
            push_open(c, KIND_SQUARE);
            return 1'b0;
         end
         CH_RROUND, CH_RCURLY, CH_RSQUARE: begin
            want = (c.ch == CH_RROUND) ? KIND_ROUND :
                   (c.ch == CH_RCURLY) ? KIND_CURLY : KIND_SQUARE;
            if (top_is(want)) return pop_pair(c, LEN_SINGLE, p);
            mark_top();
            return 1'b0;
         end
         CH_SPACE, CH_TAB, CH_AT: return 1'b0;
         default: begin
            mark_top();
            return 1'b0;
         end
      endcase
   endfunction

   function automatic string pair_text(input pair_t p);
      return $sformatf("open %0d:%0d len %0d close %0d:%0d len %0d kind %0d ovf %0d",
                       p.open_row, p.open_col, p.open_len, p.close_row, p.close_col,
                       p.close_len, p.kind, p.ovf);
   endfunction

   function automatic void report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
   endfunction

   function automatic void check_pair();
      pair_t got, want;
      got.open_row  = rsp_tdata[15:0];
      got.open_col  = rsp_tdata[27:16];
      got.open_len  = rsp_tdata[29:28];
      got.close_row = rsp_tdata[45:30];
      got.close_col = rsp_tdata[57:46];
      got.close_len = rsp_tdata[59:58];
      got.ovf       = rsp_tdata[60];
      got.kind      = rsp_tuser;
      if (pending_pairs.size() == 0) begin
         report_mismatch({"unexpected pair: ", pair_text(got)});
         return;
      end
      want = pending_pairs.pop_front();
      if (got.open_row !== want.open_row || got.open_col !== want.open_col ||
          got.open_len !== want.open_len || got.close_row !== want.close_row ||
          got.close_col !== want.close_col || got.close_len !== want.close_len ||
          got.kind !== want.kind || got.ovf !== want.ovf)
         report_mismatch({"pair mismatch: expected ", pair_text(want),
                          " / actual ", pair_text(got)});
   endfunction

   // one transfer on the request side; leaves the caller at a falling edge
   task automatic send_char(input char_t c, input bit typed, input bit typed_hit,
                            input pair_t typed_pair);
      pair_t p;
      bit hit;
      int gap;
      gap = req_fast ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {3'b000, c.hn, c.nx, c.ch, c.col, c.row};
      req_tuser  = c.sot;
      do @(posedge clock); while (!req_tready);
      hit = predict_pair(c, p);
      if (typed) begin
         hit = typed_hit;
         p   = typed_pair;
      end
      if (hit) pending_pairs = {pending_pairs, p};
      @(negedge clock);
   endtask

   function automatic logic [7:0] bracket_char(input logic [1:0] kind, input bit closing);
      case (kind)
         KIND_ROUND:  return closing ? CH_RROUND : CH_LROUND;
         KIND_CURLY:  return closing ? CH_RCURLY : CH_LCURLY;
         default:     return closing ? CH_RSQUARE : CH_LSQUARE;
      endcase
   endfunction

   function automatic logic [7:0] any_bracket();
      return bracket_char(2'($urandom_range(0, 2)), 1'($urandom));
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 2))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         default: return CH_AT;
      endcase
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] b;
      b = 8'($urandom);
      if (b inside {CH_LROUND, CH_RROUND, CH_LCURLY, CH_RCURLY, CH_LSQUARE, CH_RSQUARE})
         b = CH_UPPER_A;
      return b;
   endfunction

   function automatic void add_char(input logic [7:0] b);
      line_buf = {line_buf, b};
   endfunction

   function automatic logic [1:0] take_open_kind();
      int k;
      k = open_kinds[open_kinds.size() - 1];
      open_kinds.delete(open_kinds.size() - 1);
      return 2'(k);
   endfunction

   function automatic void add_open(input logic [1:0] kind);
      add_char(bracket_char(kind, 1'b0));
      if (kind == KIND_DOUBLE) add_char(CH_LSQUARE);
      open_kinds = {open_kinds, int'(kind)};
   endfunction

   function automatic void add_close(input logic [1:0] kind);
      add_char(bracket_char(kind, 1'b1));
      if (kind == KIND_DOUBLE) add_char(CH_RSQUARE);
   endfunction

   function automatic void flush_line();
      char_t c;
      logic [11:0] col0;
      col0 = 12'($urandom);
      for (int i = 0; i < line_buf.size(); i++) begin
         c.sot = doc_first;
         doc_first = 1'b0;
         c.row = doc_row;
         c.col = col0 + 12'(i);
         c.ch  = line_buf[i];
         c.hn  = (i + 1 < line_buf.size());
         c.nx  = c.hn ? line_buf[i + 1] : 8'($urandom);
         doc_chars = {doc_chars, c};
      end
      line_buf.delete();
      doc_row++;
   endfunction

   // mostly nested bracket text; some documents overrun the stack, some are noise
   function automatic void build_document();
      char_t c;
      int target;
      int pick;
      doc_chars.delete();
      line_buf.delete();
      open_kinds.delete();
      doc_first = 1'b1;
      doc_row   = 16'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(10, 60)) begin
            c.sot = ($urandom_range(0, 7) == 0);
            c.row = 16'($urandom);
            c.col = 12'($urandom);
            c.ch  = $urandom_range(0, 1) ? any_bracket() : 8'($urandom);
            c.nx  = $urandom_range(0, 1) ? any_bracket() : 8'($urandom);
            c.hn  = 1'($urandom);
            doc_chars = {doc_chars, c};
         end
         return;
      end
      target = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 120) : $urandom_range(4, 40);
      if ($urandom_range(0, 11) == 0) begin
         repeat ($urandom_range(DEPTH + 1, DEPTH + 16)) add_open(2'($urandom_range(0, 3)));
         target = line_buf.size() + $urandom_range(20, 60);
      end
      while (doc_chars.size() + line_buf.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) add_open(2'($urandom_range(0, 3)));
         else if (pick < 50 && open_kinds.size() != 0) add_close(take_open_kind());
         else if (pick < 65) add_char(blank_char());
         else if (pick < 85) add_char(plain_char());
         else if (pick < 90) add_char(bracket_char(2'($urandom_range(0, 3)), 1'b1));
         else flush_line();
      end
      while (open_kinds.size() != 0 && $urandom_range(0, 9) != 0)
         add_close(take_open_kind());
      flush_line();
   endfunction

   // result side: random stall before each transfer unless rsp_fast is set
   initial begin
      int stall;
      while (reset) @(negedge clock);
      forever begin
         stall = rsp_fast ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_pair();
         @(negedge clock);
      end
   end

   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle = 0;
         end else begin
            idle++;
            if (idle >= IDLE_LIMIT) begin
               $display("TEST FAILED");
               $finish;
            end
         end
      end
   end

   initial begin
      script_row_t script [SCRIPT_LEN];
      int random_sent;
      script = '{
         '{'{1'b1, 16'd0, 12'd0, CH_LROUND, CH_RROUND, 1'b1}, 1'b1, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd0, 12'd1, CH_RROUND, 8'h00, 1'b0}, 1'b1, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd0, 12'd2, CH_LROUND, 8'h61, 1'b1}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd0, 12'd3, 8'h61, CH_RROUND, 1'b1}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd0, 12'd4, CH_RROUND, 8'hff, 1'b0}, 1'b1, 1'b1,
           '{16'd0, 12'd2, LEN_SINGLE, 16'd0, 12'd4, LEN_SINGLE, KIND_ROUND, 1'b0}},
         '{'{1'b0, 16'd1, 12'd0, CH_LCURLY, 8'h00, 1'b0}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd2, 12'd4095, CH_RCURLY, 8'hff, 1'b0}, 1'b1, 1'b1,
           '{16'd1, 12'd0, LEN_SINGLE, 16'd2, 12'd4095, LEN_SINGLE, KIND_CURLY, 1'b0}},
         '{'{1'b0, 16'd3, 12'd0, CH_LSQUARE, CH_LSQUARE, 1'b1}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd3, 12'd1, CH_LSQUARE, CH_SPACE, 1'b1}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd3, 12'd2, CH_SPACE, CH_AT, 1'b1}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd3, 12'd3, CH_AT, CH_TAB, 1'b1}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd3, 12'd4, CH_TAB, CH_RSQUARE, 1'b1}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd3, 12'd5, CH_RSQUARE, CH_RSQUARE, 1'b1}, 1'b1, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd3, 12'd6, CH_RSQUARE, 8'h00, 1'b0}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd65535, 12'd4095, CH_LSQUARE, CH_LSQUARE, 1'b0}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd0, 12'd0, CH_RSQUARE, CH_RSQUARE, 1'b1}, 1'b1, 1'b1,
           '{16'd65535, 12'd4095, LEN_SINGLE, 16'd0, 12'd0, LEN_SINGLE, KIND_SQUARE, 1'b0}},
         '{'{1'b0, 16'd0, 12'd1, CH_RSQUARE, 8'h00, 1'b0}, 1'b1, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd4, 12'd10, CH_LROUND, CH_RCURLY, 1'b1}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd4, 12'd11, CH_RCURLY, CH_RROUND, 1'b1}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd4, 12'd12, CH_RROUND, 8'h00, 1'b0}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b1, 16'd5, 12'd0, CH_LSQUARE, CH_LSQUARE, 1'b1}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd5, 12'd1, 8'hff, 8'h00, 1'b0}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd6, 12'd0, CH_LSQUARE, CH_LSQUARE, 1'b1}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b1, 16'd6, 12'd1, CH_LROUND, 8'h00, 1'b0}, 1'b0, 1'b0, NO_PAIR},
         '{'{1'b0, 16'd7, 12'd0, CH_RSQUARE, CH_RSQUARE, 1'b1}, 1'b0, 1'b0, NO_PAIR}
      };
      random_sent = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) send_char(script[i].c, script[i].typed, script[i].hit, script[i].p);

      while (random_sent < RANDOM_ITEMS) begin
         build_document();
         req_fast = ($urandom_range(0, 3) == 0);
         rsp_fast = ($urandom_range(0, 3) == 0);
         foreach (doc_chars[i]) send_char(doc_chars[i], 1'b0, 1'b0, NO_PAIR);
         random_sent += doc_chars.size();
      end
      req_tvalid = 1'b0;

      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
